/* rtl/cwfr_pkg.sv */
// Shared constants and types of the checksummed word frame receiver.
package cwfr_pkg;

  localparam int MAX_WORDS_DEF = 32;
  localparam int WORD_IDX_W    = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_BANKS     = 2;

  localparam logic [7:0] FIRST_HDR_RST  = 8'hEB;
  localparam logic [7:0] SECOND_HDR_RST = 8'h90;
  localparam logic [7:0] TAIL_RST       = 8'hBE;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL       = 2'd2;

  // One accepted frame waiting for emission.
  typedef struct packed {
    logic [WORD_IDX_W-1:0] word_count;
    logic                  signed_flag;
    logic                  bank;
  } desc_t;

endpackage

/* rtl/cwfr_if.sv */
// Channel interfaces for the received bytes, the decoded words and register writes.
interface cwfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cwfr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_value;
  logic [6:0]  word_index;
  logic        is_signed;
  logic        has_word;
  logic        last;
  modport source (output valid, output word_value, output word_index, output is_signed,
                  output has_word, output last, input ready);
  modport sink (input valid, input word_value, input word_index, input is_signed,
                input has_word, input last, output ready);
endinterface

interface cwfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/cwfr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module cwfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/cwfr_front.sv */
// Frame parser: hunts for headers, stores data bytes and queues checked frames.
module cwfr_front import cwfr_pkg::*; #(
  parameter int MaxWords = MAX_WORDS_DEF,
  localparam int AddrW = $clog2(2 * MaxWords)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cwfr_in_if.sink          in_i,
  cwfr_cfg_if.sink         cfg_i,
  output logic             wr_en_o,
  output logic             wr_odd_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output logic             push_o,
  output desc_t            desc_o,
  input  logic             done_i
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_COUNT,
    PH_DATA,
    PH_CSUM,
    PH_TAIL
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [7:0]            bc_q, bc_d;
  logic [WORD_IDX_W-1:0] wc_q, wc_d;
  logic                  sf_q, sf_d;
  logic [7:0]            sum_q, sum_d;
  logic [7:0]            rsum_q, rsum_d;
  logic                  bank_q, bank_d;
  logic [1:0]            in_use_q, in_use_d;
  logic [7:0]            hdr1_q, hdr2_q, tail_q;
  logic                  accept;
  logic [7:0]            b;
  logic [8:0]            bc_next;

  assign cfg_i.ready = 1'b1;
  // A frame may only be parsed while one of the two payload banks is free.
  assign in_i.ready  = (in_use_q != 2'(NUM_BANKS));
  assign accept      = in_i.valid & in_i.ready;
  assign b           = in_i.rx_byte;
  assign bc_next     = {1'b0, bc_q} + 9'd1;

  assign wr_odd_o  = bc_q[0];
  assign wr_data_o = b;
  assign wr_addr_o = (bank_q ? AddrW'(MaxWords) : AddrW'(0)) + AddrW'(bc_q[7:1]);
  assign desc_o    = '{word_count: wc_q, signed_flag: sf_q, bank: bank_q};

  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    wc_d    = wc_q;
    sf_d    = sf_q;
    sum_d   = sum_q;
    rsum_d  = rsum_q;
    bank_d  = bank_q;
    wr_en_o = 1'b0;
    push_o  = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (bc_q == 8'd0) begin
            if (b == hdr1_q) begin
              bc_d = 8'd1;
            end
          end else begin
            // The byte after a first header byte is consumed either way.
            bc_d = 8'd0;
            if (b == hdr2_q) begin
              phase_d = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          wc_d  = b[7:1];
          sf_d  = b[0];
          sum_d = 8'd0;
          bc_d  = 8'd0;
          if (b[7:1] > WORD_IDX_W'(MaxWords)) begin
            phase_d = PH_HUNT;
          end else if (b[7:1] == '0) begin
            phase_d = PH_CSUM;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en_o = 1'b1;
          sum_d   = sum_q + b;
          bc_d    = bc_next[7:0];
          if (bc_next >= {1'b0, wc_q, 1'b0}) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          rsum_d  = b;
          phase_d = PH_TAIL;
        end
        PH_TAIL: begin
          if ((b == tail_q) && (sum_q == rsum_q)) begin
            push_o = 1'b1;
            bank_d = ~bank_q;
          end
          phase_d = PH_HUNT;
          bc_d    = 8'd0;
        end
        default: begin
          phase_d = PH_HUNT;
          bc_d    = 8'd0;
        end
      endcase
    end
    in_use_d = in_use_q + {1'b0, push_o} - {1'b0, done_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      bc_q     <= 8'd0;
      wc_q     <= '0;
      sf_q     <= 1'b0;
      sum_q    <= 8'd0;
      rsum_q   <= 8'd0;
      bank_q   <= 1'b0;
      in_use_q <= 2'd0;
      hdr1_q   <= FIRST_HDR_RST;
      hdr2_q   <= SECOND_HDR_RST;
      tail_q   <= TAIL_RST;
    end else begin
      phase_q  <= phase_d;
      bc_q     <= bc_d;
      wc_q     <= wc_d;
      sf_q     <= sf_d;
      sum_q    <= sum_d;
      rsum_q   <= rsum_d;
      bank_q   <= bank_d;
      in_use_q <= in_use_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_FIRST_HDR:  hdr1_q <= cfg_i.data;
          REG_SECOND_HDR: hdr2_q <= cfg_i.data;
          REG_TAIL:       tail_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/cwfr_desc_fifo.sv */
// Two-entry queue of checked frames between the parser and the word emitter.
module cwfr_desc_fifo import cwfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t desc_o
);

  desc_t      entry_q [NUM_BANKS];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign desc_o  = entry_q[rptr_q];

  // The parser never holds more checked frames than there are banks, so no full check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

endmodule

/* rtl/cwfr_back.sv */
// Word emitter: reads a checked frame's bytes and presents them as result items.
module cwfr_back import cwfr_pkg::*; #(
  parameter int MaxWords = MAX_WORDS_DEF,
  localparam int AddrW = $clog2(2 * MaxWords)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_valid_i,
  input  desc_t            desc_i,
  output logic             pop_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_lo_i,
  input  logic [7:0]       rd_hi_i,
  output logic             done_o,
  cwfr_out_if.source       out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  state_e                state_q;
  desc_t                 cur_q;
  logic [WORD_IDX_W-1:0] k_q;
  logic                  ov_q;
  logic [15:0]           val_q;
  logic [WORD_IDX_W-1:0] idx_q;
  logic                  sgn_q, hw_q, last_q;
  logic                  out_free;
  logic                  is_last;

  assign out_free  = !ov_q || out_o.ready;
  assign is_last   = ({1'b0, k_q} + 8'd1) == {1'b0, cur_q.word_count};
  assign rd_addr_o = (cur_q.bank ? AddrW'(MaxWords) : AddrW'(0)) + AddrW'(k_q);
  assign rd_en_o   = (state_q == S_READ) && out_free;
  assign pop_o     = (state_q == S_IDLE) && desc_valid_i &&
                     ((desc_i.word_count != '0) || out_free);
  assign done_o    = ((state_q == S_IDLE) && pop_o && (desc_i.word_count == '0)) ||
                     ((state_q == S_LOAD) && is_last);

  assign out_o.valid      = ov_q;
  assign out_o.word_value = val_q;
  assign out_o.word_index = idx_q;
  assign out_o.is_signed  = sgn_q;
  assign out_o.has_word   = hw_q;
  assign out_o.last       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cur_q   <= '0;
      k_q     <= '0;
      val_q   <= '0;
      idx_q   <= '0;
      sgn_q   <= 1'b0;
      hw_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cur_q <= desc_i;
            k_q   <= '0;
            if (desc_i.word_count == '0) begin
              ov_q   <= 1'b1;
              val_q  <= 16'd0;
              idx_q  <= '0;
              sgn_q  <= desc_i.signed_flag;
              hw_q   <= 1'b0;
              last_q <= 1'b1;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rd_en_o) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          // The read was only issued with the output register free by now.
          ov_q   <= 1'b1;
          val_q  <= {rd_hi_i, rd_lo_i};
          idx_q  <= k_q;
          sgn_q  <= cur_q.signed_flag;
          hw_q   <= 1'b1;
          last_q <= is_last;
          k_q    <= k_q + 1'b1;
          state_q <= is_last ? S_IDLE : S_READ;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/checksummed_word_frame_receiver_unit.sv */
// Top level of the checksummed word frame receiver.
// Received bytes are taken one per cycle while byte input is not stalled, and a checked
// frame's words then come out one at a time, each through a registered read of the two
// payload RAMs and then the output register; an empty frame gives its single marker item
// straight from the idle state. The payload store has two banks, so the parser runs ahead
// into the next frame while the emitter drains the last one; byte input stalls only while
// two checked frames are not yet fully emitted. Register writes are taken in every cycle,
// and writes to an index beyond the tail register are ignored.
module checksummed_word_frame_receiver_unit import cwfr_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwfr_in_if.sink    in_i,
  cwfr_cfg_if.sink   cfg_i,
  cwfr_out_if.source out_o
);

  localparam int Depth = 2 * MAX_WORDS;
  localparam int AddrW = $clog2(Depth);

  logic             wr_en, wr_odd, push, done, pop, desc_valid, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_lo, rd_hi;
  desc_t            desc_in, desc_out;

  cwfr_front #(.MaxWords(MAX_WORDS)) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .cfg_i,
    .wr_en_o   (wr_en),
    .wr_odd_o  (wr_odd),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .desc_o    (desc_in),
    .done_i    (done)
  );

  cwfr_desc_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .desc_i  (desc_in),
    .pop_i   (pop),
    .valid_o (desc_valid),
    .desc_o  (desc_out)
  );

  // Even-numbered data bytes are the low halves of words, odd-numbered the high halves.
  cwfr_ram #(.Width(8), .Depth(Depth)) u_ram_lo (
    .clk_i,
    .we_i    (wr_en & ~wr_odd),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_lo)
  );

  cwfr_ram #(.Width(8), .Depth(Depth)) u_ram_hi (
    .clk_i,
    .we_i    (wr_en & wr_odd),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_hi)
  );

  cwfr_back #(.MaxWords(MAX_WORDS)) u_back (
    .clk_i,
    .rst_ni,
    .desc_valid_i (desc_valid),
    .desc_i       (desc_out),
    .pop_o        (pop),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_lo_i      (rd_lo),
    .rd_hi_i      (rd_hi),
    .done_o       (done),
    .out_o
  );

endmodule
